// ----- rtl/core/sots_pkg.sv -----
// shared types and codes for the timed output schedule table
// no dependencies; compile first
`default_nettype none

package sots_pkg;

	// default sizing of the table
	localparam int TABLE_DEPTH_DEF = 16;
	localparam int TIME_BITS_DEF   = 32;

	// at most this many output writes per tick
	localparam int MAX_WRITES = 16;
	localparam int CNT_W      = $clog2(MAX_WRITES + 1);

	// fixed payload widths
	localparam int OPCODE_W = 2;
	localparam int ID_W     = 8;
	localparam int KIND_W   = 3;
	localparam int IN_TIME_W = 32;

	// item opcodes
	localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_WRITE     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FULL      = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REMOVED   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd4;

	// one result as handed from the sequencer to the output register
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   write_id;
		logic              write_level;
		logic              last;
	} res_t;

endpackage

`default_nettype wire

// ----- rtl/core/sots_if.sv -----
// valid/ready channel interfaces for the schedule table
// depends on sots_pkg
`default_nettype none

// input item channel
interface sots_in_if;
	import sots_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [OPCODE_W-1:0]  opcode;
	logic [ID_W-1:0]      output_id;
	logic                 output_level;
	logic [IN_TIME_W-1:0] tick_time;

	modport source (output valid, output opcode, output output_id, output output_level,
		output tick_time, input ready);
	modport sink (input valid, input opcode, input output_id, input output_level,
		input tick_time, output ready);
endinterface

// result channel
interface sots_out_if;
	import sots_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [ID_W-1:0]   write_id;
	logic              write_level;
	logic              last;

	modport source (output valid, output kind, output write_id, output write_level,
		output last, input ready);
	modport sink (input valid, input kind, input write_id, input write_level,
		input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sots_entry_ram.sv -----
// entry store of the schedule table: one write port, one registered read port
// no package dependency
`default_nettype none

module sots_entry_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 41,
	parameter int AW    = 4
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- rtl/core/sots_match.sv -----
// shared slot comparator: entry against the key of the current item
// depends on sots_pkg
`default_nettype none

module sots_match #(
	parameter int TIME_BITS = 32
) (
	input  wire logic                     slot_valid,
	input  wire logic [sots_pkg::ID_W-1:0] e_id,
	input  wire logic                     e_level,
	input  wire logic [TIME_BITS-1:0]     e_time,
	input  wire logic [sots_pkg::ID_W-1:0] k_id,
	input  wire logic                     k_level,
	input  wire logic [TIME_BITS-1:0]     k_time,
	input  wire logic                     all_fields,
	output logic                          hit
);
	import sots_pkg::*;

	logic time_eq;
	logic rest_eq;

	// time always compared; light and level only for a remove
	always_comb begin
		time_eq = (e_time == k_time);
		rest_eq = (e_id == k_id) && (e_level == k_level);
		hit     = slot_valid && time_eq && (!all_fields || rest_eq);
	end

endmodule

`default_nettype wire

// ----- rtl/core/sots_ctrl.sv -----
// scan sequencer: slot valid bits, one slot per cycle through the comparator
// unless a tick waits on the output; depends on sots_pkg, sots_match
`default_nettype none

module sots_ctrl #(
	parameter int TABLE_DEPTH = 16,
	parameter int TIME_BITS   = 32,
	parameter int IW          = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [sots_pkg::OPCODE_W-1:0] op,
	input  wire logic [sots_pkg::ID_W-1:0]     id,
	input  wire logic                         level,
	input  wire logic [TIME_BITS-1:0]         key_time,
	input  wire logic                         can_emit,
	output logic                              busy,
	output logic                              emit,
	output sots_pkg::res_t                    res,
	output logic                              wr_en,
	output logic [IW-1:0]                     wr_addr,
	output logic [sots_pkg::ID_W+TIME_BITS:0] wr_data,
	output logic [IW-1:0]                     rd_addr,
	input  wire logic [sots_pkg::ID_W+TIME_BITS:0] rd_data
);
	import sots_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam logic [IW-1:0]    LAST_IDX = IW'(TABLE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_WRITES);

	logic [1:0]             state_q, state_d;
	logic [IW-1:0]          idx_q, idx_d;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic                   set_valid, clr_valid;

	// current item
	logic [OPCODE_W-1:0]  op_q;
	logic [ID_W-1:0]      id_q;
	logic                 level_q;
	logic [TIME_BITS-1:0] time_q;

	// result held back until its successor or the end of the scan is known
	logic              pend_valid_q, pend_valid_d;
	logic [KIND_W-1:0] pend_kind_q, pend_kind_d;
	logic [ID_W-1:0]   pend_id_q, pend_id_d;
	logic              pend_level_q, pend_level_d;

	// fields of the slot being looked at
	logic [ID_W-1:0]      e_id;
	logic                 e_level;
	logic [TIME_BITS-1:0] e_time;
	logic                 hit;
	logic                 last_slot;
	logic                 take;

	assign e_id      = rd_data[ID_W+TIME_BITS:TIME_BITS+1];
	assign e_level   = rd_data[TIME_BITS];
	assign e_time    = rd_data[TIME_BITS-1:0];
	assign last_slot = (idx_q == LAST_IDX);

	sots_match #(
		.TIME_BITS(TIME_BITS)
	) u_match (
		.slot_valid (valid_q[idx_q]),
		.e_id       (e_id),
		.e_level    (e_level),
		.e_time     (e_time),
		.k_id       (id_q),
		.k_level    (level_q),
		.k_time     (time_q),
		.all_fields (op_q == OP_REMOVE),
		.hit        (hit)
	);

	// sequencer
	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		cnt_d        = cnt_q;
		pend_valid_d = pend_valid_q;
		pend_kind_d  = pend_kind_q;
		pend_id_d    = pend_id_q;
		pend_level_d = pend_level_q;
		emit         = 1'b0;
		res          = '0;
		wr_en        = 1'b0;
		set_valid    = 1'b0;
		clr_valid    = 1'b0;
		take         = hit && (cnt_q != CNT_MAX);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					idx_d        = '0;
					cnt_d        = '0;
					pend_valid_d = 1'b0;
					if (op == OP_TICK || op == OP_ADD || op == OP_REMOVE) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				case (op_q)
					OP_TICK: begin
						// a new match pushes out the one before it, if there is room
						if (!(take && pend_valid_q && !can_emit)) begin
							if (take) begin
								if (pend_valid_q) begin
									emit = 1'b1;
									res  = '{kind: KIND_WRITE, write_id: pend_id_q,
										write_level: pend_level_q, last: 1'b0};
								end
								pend_valid_d = 1'b1;
								pend_kind_d  = KIND_WRITE;
								pend_id_d    = e_id;
								pend_level_d = e_level;
								cnt_d        = cnt_q + 1'b1;
							end
							if (last_slot) begin
								state_d = ST_DONE;
							end else begin
								idx_d = idx_q + 1'b1;
							end
						end
					end
					OP_ADD: begin
						if (!valid_q[idx_q]) begin
							wr_en        = 1'b1;
							set_valid    = 1'b1;
							pend_valid_d = 1'b1;
							pend_kind_d  = KIND_ADDED;
							pend_id_d    = '0;
							pend_level_d = 1'b0;
							state_d      = ST_DONE;
						end else if (last_slot) begin
							pend_valid_d = 1'b1;
							pend_kind_d  = KIND_FULL;
							pend_id_d    = '0;
							pend_level_d = 1'b0;
							state_d      = ST_DONE;
						end else begin
							idx_d = idx_q + 1'b1;
						end
					end
					OP_REMOVE: begin
						if (hit) begin
							clr_valid    = 1'b1;
							pend_valid_d = 1'b1;
							pend_kind_d  = KIND_REMOVED;
							pend_id_d    = '0;
							pend_level_d = 1'b0;
							state_d      = ST_DONE;
						end else if (last_slot) begin
							pend_valid_d = 1'b1;
							pend_kind_d  = KIND_NOT_FOUND;
							pend_id_d    = '0;
							pend_level_d = 1'b0;
							state_d      = ST_DONE;
						end else begin
							idx_d = idx_q + 1'b1;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_DONE: begin
				// final result of the item, marked last
				if (!pend_valid_q) begin
					state_d = ST_IDLE;
				end else if (can_emit) begin
					emit         = 1'b1;
					res          = '{kind: pend_kind_q, write_id: pend_id_q,
						write_level: pend_level_q, last: 1'b1};
					pend_valid_d = 1'b0;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// read the slot that is looked at next cycle
	assign rd_addr = idx_d;
	assign wr_addr = idx_q;
	assign wr_data = {id_q, level_q, time_q};
	assign busy    = (state_q != ST_IDLE);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			valid_q      <= '0;
		end else begin
			state_q      <= state_d;
			idx_q        <= idx_d;
			cnt_q        <= cnt_d;
			pend_valid_q <= pend_valid_d;
			if (set_valid) begin
				valid_q[idx_q] <= 1'b1;
			end
			if (clr_valid) begin
				valid_q[idx_q] <= 1'b0;
			end
		end
	end

	// item fields and held result
	always_ff @(posedge clk) begin
		if (start) begin
			op_q    <= op;
			id_q    <= id;
			level_q <= level;
			time_q  <= key_time;
		end
		pend_kind_q  <= pend_kind_d;
		pend_id_q    <= pend_id_d;
		pend_level_q <= pend_level_d;
	end

endmodule

`default_nettype wire

// ----- rtl/core/timed_output_schedule_table_core.sv -----
// top level of the timed output schedule table
// depends on sots_pkg, sots_if, sots_entry_ram, sots_ctrl
`default_nettype none

// A table of TABLE_DEPTH scheduled output events (light number, level, trigger
// time). Opcode 3 is taken and dropped; the rest walk the slots in order,
// one slot per cycle unless a tick waits on the output, through the single read
// port of the entry memory and one shared comparator; the block takes no new
// item during the walk. A tick walks all slots and emits up to MAX_WRITES
// output writes, the last one marked. An add stops at the first free slot and
// a remove at the first match, each with one result. Results pass through an
// output register; the walk waits while the sink holds back a result and
// another is ready to leave. Only the low TIME_BITS bits of tick_time are used.
module timed_output_schedule_table_core #(
	parameter int TABLE_DEPTH = sots_pkg::TABLE_DEPTH_DEF,
	parameter int TIME_BITS   = sots_pkg::TIME_BITS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	sots_in_if.sink   req,
	sots_out_if.source rsp
);
	import sots_pkg::*;

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int EW = ID_W + 1 + TIME_BITS;

	logic                 start;
	logic                 busy;
	logic                 emit;
	logic                 can_emit;
	res_t                 res;
	logic [TIME_BITS-1:0] key_time;
	logic                 wr_en;
	logic [IW-1:0]        wr_addr;
	logic [EW-1:0]        wr_data;
	logic [IW-1:0]        rd_addr;
	logic [EW-1:0]        rd_data;

	logic rsp_valid_q;
	res_t rsp_res_q;

	assign req.ready = !busy;
	assign start     = req.valid && !busy;
	assign key_time  = TIME_BITS'(req.tick_time);
	assign can_emit  = !rsp_valid_q || rsp.ready;

	sots_entry_ram #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (EW),
		.AW    (IW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sots_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.TIME_BITS   (TIME_BITS),
		.IW          (IW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.op       (req.opcode),
		.id       (req.output_id),
		.level    (req.output_level),
		.key_time (key_time),
		.can_emit (can_emit),
		.busy     (busy),
		.emit     (emit),
		.res      (res),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_res_q <= res;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.kind        = rsp_res_q.kind;
	assign rsp.write_id    = rsp_res_q.write_id;
	assign rsp.write_level = rsp_res_q.write_level;
	assign rsp.last        = rsp_res_q.last;

	// a new result never overwrites one the sink has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit && rsp_valid_q |-> rsp.ready)
		else $error("result written over a pending transaction");

	// add and remove always scan, so the block is busy the next cycle
	a_busy_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && (req.opcode == OP_ADD || req.opcode == OP_REMOVE)
		|=> !req.ready)
		else $error("ready right after an add or remove transaction");

	// status results are single and therefore always last
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit && res.kind != KIND_WRITE |-> res.last)
		else $error("status result not marked last");

endmodule

`default_nettype wire
